// ----- sv/pdbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel deprojection package
// Shared widths, fixed-point types, register codes and the saturation helper.
// ----------------------------------------------------------------------------
package pdbc_pkg;

    localparam int PIX_W     = 16;
    localparam int DEPTH_W   = 16;
    localparam int FOCAL_W   = 24;
    localparam int COEF_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MID_W     = 48;
    localparam int HALF_W    = MID_W / 2;
    localparam int PROD_W    = 2 * MID_W;
    localparam int SUM_W     = MID_W + 4;
    localparam int Q_SHIFT   = 28;
    localparam int OUT_W     = 40;
    localparam int OUT_SHIFT = 20;
    localparam int MUL_LAT   = 5;
    localparam int SCALE_LAT = 4;

    typedef logic signed [MID_W-1:0] mid_t;
    typedef logic [MID_W-1:0]        mag_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [OUT_W-1:0] out_t;
    typedef logic [DEPTH_W-1:0]      depth_t;

    localparam mid_t MID_MAX = {1'b0, {(MID_W-1){1'b1}}};
    localparam sum_t Q_ONE   = sum_t'(64'd1 << Q_SHIFT);
    localparam out_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam out_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [FOCAL_W-1:0] INV_FOCAL_RESET = 24'd27962;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_POINT,
        CFG_INV_FOCAL_X,
        CFG_INV_FOCAL_Y,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2,
        CFG_RADIAL_K3,
        CFG_TANGENTIAL_P1,
        CFG_TANGENTIAL_P2
    } cfg_reg_e;

    function automatic mid_t sat_mid(input sum_t v);
        mid_t r;
        if (v > sum_t'(MID_MAX))
        begin
            r = MID_MAX;
        end
        else if (v < -sum_t'(MID_MAX))
        begin
            r = -MID_MAX;
        end
        else
        begin
            r = v[MID_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pdbc_qmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined fixed-point multiplier
// Multiplies two signed Q.28 values, truncates toward zero to Q.28 and
// saturates the result to the intermediate range, over five stages.
// ----------------------------------------------------------------------------
module pdbc_qmul
(
    input  wire logic                          clk,
    input  wire logic [pdbc_pkg::MUL_LAT-1:0]  en,
    input  wire pdbc_pkg::mid_t                a,
    input  wire pdbc_pkg::mid_t                b,
    output pdbc_pkg::mid_t                     p
);

    localparam int MID_W  = pdbc_pkg::MID_W;
    localparam int HALF_W = pdbc_pkg::HALF_W;
    localparam int PROD_W = pdbc_pkg::PROD_W;
    localparam int Q_SH   = pdbc_pkg::Q_SHIFT;

    pdbc_pkg::mag_t            mag_a_reg, mag_b_reg;
    pdbc_pkg::mag_t            mag_a_next, mag_b_next;
    logic                      neg_reg [0:3];
    logic [2*HALF_W-1:0]       p00_reg, p01_reg, p10_reg, p11_reg;
    logic [2*HALF_W-1:0]       p00_next, p01_next, p10_next, p11_next;
    logic [2*HALF_W-1:0]       lo_reg, hi_reg;
    logic [2*HALF_W:0]         mid_reg, mid_next;
    logic [PROD_W-1:0]         full_reg, full_next;
    pdbc_pkg::mag_t            mag_r;
    pdbc_pkg::mid_t            p_reg, p_next;

    always_comb
    begin
        mag_a_next = a[MID_W-1] ? pdbc_pkg::mag_t'(-a) : pdbc_pkg::mag_t'(a);
        mag_b_next = b[MID_W-1] ? pdbc_pkg::mag_t'(-b) : pdbc_pkg::mag_t'(b);

        p00_next = mag_a_reg[HALF_W-1:0] * mag_b_reg[HALF_W-1:0];
        p01_next = mag_a_reg[HALF_W-1:0] * mag_b_reg[MID_W-1:HALF_W];
        p10_next = mag_a_reg[MID_W-1:HALF_W] * mag_b_reg[HALF_W-1:0];
        p11_next = mag_a_reg[MID_W-1:HALF_W] * mag_b_reg[MID_W-1:HALF_W];

        mid_next = {1'b0, p01_reg} + {1'b0, p10_reg};

        full_next = PROD_W'(lo_reg) + (PROD_W'(mid_reg) << HALF_W)
                  + (PROD_W'(hi_reg) << MID_W);

        // Anything at or above bit 75 of the product overflows the range.
        if (|full_reg[PROD_W-1:MID_W+Q_SH-1])
        begin
            mag_r = pdbc_pkg::mag_t'(pdbc_pkg::MID_MAX);
        end
        else
        begin
            mag_r = {1'b0, full_reg[MID_W+Q_SH-2:Q_SH]};
        end
        p_next = neg_reg[3] ? -pdbc_pkg::mid_t'(mag_r) : pdbc_pkg::mid_t'(mag_r);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_a_reg  <= mag_a_next;
            mag_b_reg  <= mag_b_next;
            neg_reg[0] <= a[MID_W-1] ^ b[MID_W-1];
        end
        if (en[1])
        begin
            p00_reg    <= p00_next;
            p01_reg    <= p01_next;
            p10_reg    <= p10_next;
            p11_reg    <= p11_next;
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            lo_reg     <= p00_reg;
            hi_reg     <= p11_reg;
            mid_reg    <= mid_next;
            neg_reg[2] <= neg_reg[1];
        end
        if (en[3])
        begin
            full_reg   <= full_next;
            neg_reg[3] <= neg_reg[2];
        end
        if (en[4])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- sv/pdbc_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth scaler
// Multiplies a corrected Q.28 coordinate by the depth, truncates toward zero
// to Q.8 and saturates to the 40-bit output range, over four stages.
// ----------------------------------------------------------------------------
module pdbc_scale
(
    input  wire logic                            clk,
    input  wire logic [pdbc_pkg::SCALE_LAT-1:0]  en,
    input  wire pdbc_pkg::mid_t                  u,
    input  wire pdbc_pkg::depth_t                depth,
    output pdbc_pkg::out_t                       point
);

    localparam int MID_W   = pdbc_pkg::MID_W;
    localparam int HALF_W  = pdbc_pkg::HALF_W;
    localparam int DEPTH_W = pdbc_pkg::DEPTH_W;
    localparam int OUT_W   = pdbc_pkg::OUT_W;
    localparam int PP_W    = HALF_W + DEPTH_W;
    localparam int FULL_W  = MID_W + DEPTH_W;
    localparam int M_W     = FULL_W - pdbc_pkg::OUT_SHIFT;

    pdbc_pkg::mag_t     mag_reg, mag_next;
    pdbc_pkg::depth_t   depth_reg;
    logic               neg_reg [0:2];
    logic [PP_W-1:0]    lo_reg, hi_reg, lo_next, hi_next;
    logic [FULL_W-1:0]  full_sum;
    logic [M_W-1:0]     m_reg;
    logic               ovf;
    pdbc_pkg::out_t     point_reg, point_next;

    always_comb
    begin
        mag_next = u[MID_W-1] ? pdbc_pkg::mag_t'(-u) : pdbc_pkg::mag_t'(u);
        lo_next  = mag_reg[HALF_W-1:0] * depth_reg;
        hi_next  = mag_reg[MID_W-1:HALF_W] * depth_reg;
        full_sum = FULL_W'(lo_reg) + (FULL_W'(hi_reg) << HALF_W);

        ovf = |m_reg[M_W-1:OUT_W-1];
        if (neg_reg[2])
        begin
            point_next = ovf ? pdbc_pkg::OUT_MIN : -pdbc_pkg::out_t'(m_reg[OUT_W-1:0]);
        end
        else
        begin
            point_next = ovf ? pdbc_pkg::OUT_MAX : pdbc_pkg::out_t'(m_reg[OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg    <= mag_next;
            neg_reg[0] <= u[MID_W-1];
            depth_reg  <= depth;
        end
        if (en[1])
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            m_reg      <= full_sum[FULL_W-1:pdbc_pkg::OUT_SHIFT];
            neg_reg[2] <= neg_reg[1];
        end
        if (en[3])
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

`default_nettype wire

// ----- sv/pixel_deprojection_brown_conrady.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel deprojection with inverse Brown-Conrady correction
// Turns a pixel coordinate and its depth into a 3D point in millimetres.
//
// The input channel takes one pixel per transaction (pixel_x, pixel_y in
// Q12.4, depth_mm) and the output channel returns one point per transaction
// (point_x, point_y in saturated Q32.8, point_z equal to the depth).
// Both channels move a transaction on an edge where valid is high and stall
// is low. The camera registers are written through cfg_wr_en, cfg_index and
// cfg_data; the user must write them only while no transaction is in flight,
// since the block itself does not enforce this. The pipeline has 34 register
// stages, and one transaction can be accepted in every cycle unless every
// stage is full and the output is stalled. The depth is set by the chain of
// five dependent fixed-point multiplications, each of which takes five stages
// built on 24 by 24 bit partial products.
// When the receiver stalls, the held result stays on the output and empty
// stages ahead of it keep filling; in_stall rises only once every stage holds
// a transaction. Reset empties the pipeline and restores the register
// defaults.
// ----------------------------------------------------------------------------
module pixel_deprojection_brown_conrady
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pdbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pdbc_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [pdbc_pkg::PIX_W-1:0]          pixel_x,
    input  wire logic [pdbc_pkg::PIX_W-1:0]          pixel_y,
    input  wire logic [pdbc_pkg::DEPTH_W-1:0]        depth_mm,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pdbc_pkg::OUT_W-1:0]        point_x,
    output logic signed [pdbc_pkg::OUT_W-1:0]        point_y,
    output logic [pdbc_pkg::DEPTH_W-1:0]             point_z
);

    localparam int MUL_LAT    = pdbc_pkg::MUL_LAT;
    localparam int PIX_W      = pdbc_pkg::PIX_W;
    localparam int FOCAL_W    = pdbc_pkg::FOCAL_W;
    localparam int COEF_W     = pdbc_pkg::COEF_W;

    localparam int ST_OFS     = 1;
    localparam int ST_XY      = ST_OFS + 1;
    localparam int ST_SQ      = ST_XY + MUL_LAT;
    localparam int ST_R2      = ST_SQ + 1;
    localparam int ST_AXY     = ST_R2 + 1;
    localparam int ST_PXY     = ST_SQ + MUL_LAT;
    localparam int ST_R4      = ST_R2 + MUL_LAT;
    localparam int ST_TA      = ST_AXY + MUL_LAT;
    localparam int ST_T       = ST_TA + 1;
    localparam int ST_R6      = ST_R4 + MUL_LAT;
    localparam int ST_PS      = ST_R6 + 1;
    localparam int ST_K3      = ST_R6 + MUL_LAT;
    localparam int ST_F       = ST_K3 + 1;
    localparam int ST_UF      = ST_F + MUL_LAT;
    localparam int ST_U       = ST_UF + 1;
    localparam int NUM_STAGES = ST_U + pdbc_pkg::SCALE_LAT;

    // Configuration registers.
    logic [pdbc_pkg::CFG_W-1:0]  principal_point_reg;
    logic [FOCAL_W-1:0]          inv_focal_x_reg, inv_focal_y_reg;
    logic signed [COEF_W-1:0]    radial_k1_reg, radial_k2_reg, radial_k3_reg;
    logic signed [COEF_W-1:0]    tangential_p1_reg, tangential_p2_reg;

    // Pipeline control.
    logic [NUM_STAGES:1]         v_reg, v_next, v_in, en;

    // Datapath.
    logic signed [PIX_W:0]               dx_reg, dy_reg, dx_next, dy_next;
    logic signed [PIX_W+FOCAL_W+1:0]     x_prod, y_prod;
    pdbc_pkg::mid_t                      x_reg [ST_XY:ST_F];
    pdbc_pkg::mid_t                      y_reg [ST_XY:ST_F];
    pdbc_pkg::mid_t                      xx, yy, xy;
    pdbc_pkg::mid_t                      xx_reg, yy_reg;
    pdbc_pkg::mid_t                      r2_reg [ST_R2:ST_R4];
    pdbc_pkg::mid_t                      r2_next;
    pdbc_pkg::mid_t                      ax_reg, ay_reg, ax_next, ay_next;
    pdbc_pkg::mid_t                      p1xy, p2xy, p2ax, p1ay;
    pdbc_pkg::mid_t                      p1xy_reg [ST_PXY+1:ST_TA];
    pdbc_pkg::mid_t                      p2xy_reg [ST_PXY+1:ST_TA];
    pdbc_pkg::sum_t                      tx_reg [ST_T:ST_UF];
    pdbc_pkg::sum_t                      ty_reg [ST_T:ST_UF];
    pdbc_pkg::sum_t                      tx_next, ty_next;
    pdbc_pkg::mid_t                      r4, k1r2, r6, k2r4, k3r6;
    pdbc_pkg::mid_t                      k1r2_reg [ST_R4+1:ST_R6];
    pdbc_pkg::sum_t                      psum_reg [ST_PS:ST_K3];
    pdbc_pkg::sum_t                      psum_next;
    pdbc_pkg::mid_t                      f_reg, f_next;
    pdbc_pkg::mid_t                      xf, yf;
    pdbc_pkg::mid_t                      ux_reg, uy_reg, ux_next, uy_next;
    pdbc_pkg::depth_t                    depth_reg [ST_OFS:NUM_STAGES];

    // ------------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_point_reg <= '0;
            inv_focal_x_reg     <= pdbc_pkg::INV_FOCAL_RESET;
            inv_focal_y_reg     <= pdbc_pkg::INV_FOCAL_RESET;
            radial_k1_reg       <= '0;
            radial_k2_reg       <= '0;
            radial_k3_reg       <= '0;
            tangential_p1_reg   <= '0;
            tangential_p2_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (pdbc_pkg::cfg_reg_e'(cfg_index))
                pdbc_pkg::CFG_PRINCIPAL_POINT: principal_point_reg <= cfg_data;
                pdbc_pkg::CFG_INV_FOCAL_X:     inv_focal_x_reg <= cfg_data[FOCAL_W-1:0];
                pdbc_pkg::CFG_INV_FOCAL_Y:     inv_focal_y_reg <= cfg_data[FOCAL_W-1:0];
                pdbc_pkg::CFG_RADIAL_K1:       radial_k1_reg <= $signed(cfg_data[COEF_W-1:0]);
                pdbc_pkg::CFG_RADIAL_K2:       radial_k2_reg <= $signed(cfg_data[COEF_W-1:0]);
                pdbc_pkg::CFG_RADIAL_K3:       radial_k3_reg <= $signed(cfg_data[COEF_W-1:0]);
                pdbc_pkg::CFG_TANGENTIAL_P1:   tangential_p1_reg <= $signed(cfg_data[COEF_W-1:0]);
                pdbc_pkg::CFG_TANGENTIAL_P2:   tangential_p2_reg <= $signed(cfg_data[COEF_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or when everything
    // after it moves, so bubbles are squeezed out behind a stalled result.
    // ------------------------------------------------------------------------
    for (genvar g = 1; g <= NUM_STAGES; g++)
    begin : g_en
        assign en[g] = !((&v_reg[NUM_STAGES:g]) && out_stall);
    end

    assign v_in   = {v_reg[NUM_STAGES-1:1], in_valid};
    assign v_next = (en & v_in) | (~en & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = v_reg[NUM_STAGES];

    // ------------------------------------------------------------------------
    // Stage arithmetic.
    // ------------------------------------------------------------------------
    always_comb
    begin
        dx_next = $signed({1'b0, pixel_x})
                - $signed({1'b0, principal_point_reg[2*PIX_W-1:PIX_W]});
        dy_next = $signed({1'b0, pixel_y})
                - $signed({1'b0, principal_point_reg[PIX_W-1:0]});

        x_prod = dx_reg * $signed({1'b0, inv_focal_x_reg});
        y_prod = dy_reg * $signed({1'b0, inv_focal_y_reg});

        r2_next = pdbc_pkg::sat_mid(pdbc_pkg::sum_t'(xx) + pdbc_pkg::sum_t'(yy));

        ax_next = pdbc_pkg::sat_mid(pdbc_pkg::sum_t'(r2_reg[ST_R2])
                                    + (pdbc_pkg::sum_t'(xx_reg) <<< 1));
        ay_next = pdbc_pkg::sat_mid(pdbc_pkg::sum_t'(r2_reg[ST_R2])
                                    + (pdbc_pkg::sum_t'(yy_reg) <<< 1));

        tx_next = (pdbc_pkg::sum_t'(p1xy_reg[ST_TA]) <<< 1) + pdbc_pkg::sum_t'(p2ax);
        ty_next = (pdbc_pkg::sum_t'(p2xy_reg[ST_TA]) <<< 1) + pdbc_pkg::sum_t'(p1ay);

        psum_next = pdbc_pkg::Q_ONE + pdbc_pkg::sum_t'(k1r2_reg[ST_R6])
                  + pdbc_pkg::sum_t'(k2r4);

        f_next = pdbc_pkg::sat_mid(psum_reg[ST_K3] + pdbc_pkg::sum_t'(k3r6));

        ux_next = pdbc_pkg::sat_mid(pdbc_pkg::sum_t'(xf) + tx_reg[ST_UF]);
        uy_next = pdbc_pkg::sat_mid(pdbc_pkg::sum_t'(yf) + ty_reg[ST_UF]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OFS])
        begin
            dx_reg            <= dx_next;
            dy_reg            <= dy_next;
            depth_reg[ST_OFS] <= depth_mm;
        end
        if (en[ST_XY])
        begin
            x_reg[ST_XY] <= pdbc_pkg::mid_t'(x_prod);
            y_reg[ST_XY] <= pdbc_pkg::mid_t'(y_prod);
        end
        if (en[ST_R2])
        begin
            r2_reg[ST_R2] <= r2_next;
            xx_reg        <= xx;
            yy_reg        <= yy;
        end
        if (en[ST_AXY])
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (en[ST_PXY+1])
        begin
            p1xy_reg[ST_PXY+1] <= p1xy;
            p2xy_reg[ST_PXY+1] <= p2xy;
        end
        if (en[ST_T])
        begin
            tx_reg[ST_T] <= tx_next;
            ty_reg[ST_T] <= ty_next;
        end
        if (en[ST_R4+1])
        begin
            k1r2_reg[ST_R4+1] <= k1r2;
        end
        if (en[ST_PS])
        begin
            psum_reg[ST_PS] <= psum_next;
        end
        if (en[ST_F])
        begin
            f_reg <= f_next;
        end
        if (en[ST_U])
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end

        for (int k = ST_OFS + 1; k <= NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                depth_reg[k] <= depth_reg[k-1];
            end
        end
        for (int k = ST_XY + 1; k <= ST_F; k++)
        begin
            if (en[k])
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
            end
        end
        for (int k = ST_R2 + 1; k <= ST_R4; k++)
        begin
            if (en[k])
            begin
                r2_reg[k] <= r2_reg[k-1];
            end
        end
        for (int k = ST_PXY + 2; k <= ST_TA; k++)
        begin
            if (en[k])
            begin
                p1xy_reg[k] <= p1xy_reg[k-1];
                p2xy_reg[k] <= p2xy_reg[k-1];
            end
        end
        for (int k = ST_T + 1; k <= ST_UF; k++)
        begin
            if (en[k])
            begin
                tx_reg[k] <= tx_reg[k-1];
                ty_reg[k] <= ty_reg[k-1];
            end
        end
        for (int k = ST_R4 + 2; k <= ST_R6; k++)
        begin
            if (en[k])
            begin
                k1r2_reg[k] <= k1r2_reg[k-1];
            end
        end
        for (int k = ST_PS + 1; k <= ST_K3; k++)
        begin
            if (en[k])
            begin
                psum_reg[k] <= psum_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Multiplier units.
    // ------------------------------------------------------------------------
    pdbc_qmul u_mul_xx
    (
        .clk (clk),
        .en  (en[ST_XY+1 +: MUL_LAT]),
        .a   (x_reg[ST_XY]),
        .b   (x_reg[ST_XY]),
        .p   (xx)
    );

    pdbc_qmul u_mul_yy
    (
        .clk (clk),
        .en  (en[ST_XY+1 +: MUL_LAT]),
        .a   (y_reg[ST_XY]),
        .b   (y_reg[ST_XY]),
        .p   (yy)
    );

    pdbc_qmul u_mul_xy
    (
        .clk (clk),
        .en  (en[ST_XY+1 +: MUL_LAT]),
        .a   (x_reg[ST_XY]),
        .b   (y_reg[ST_XY]),
        .p   (xy)
    );

    pdbc_qmul u_mul_p1xy
    (
        .clk (clk),
        .en  (en[ST_SQ+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(tangential_p1_reg)),
        .b   (xy),
        .p   (p1xy)
    );

    pdbc_qmul u_mul_p2xy
    (
        .clk (clk),
        .en  (en[ST_SQ+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(tangential_p2_reg)),
        .b   (xy),
        .p   (p2xy)
    );

    pdbc_qmul u_mul_r4
    (
        .clk (clk),
        .en  (en[ST_R2+1 +: MUL_LAT]),
        .a   (r2_reg[ST_R2]),
        .b   (r2_reg[ST_R2]),
        .p   (r4)
    );

    pdbc_qmul u_mul_k1r2
    (
        .clk (clk),
        .en  (en[ST_R2+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(radial_k1_reg)),
        .b   (r2_reg[ST_R2]),
        .p   (k1r2)
    );

    pdbc_qmul u_mul_p2ax
    (
        .clk (clk),
        .en  (en[ST_AXY+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(tangential_p2_reg)),
        .b   (ax_reg),
        .p   (p2ax)
    );

    pdbc_qmul u_mul_p1ay
    (
        .clk (clk),
        .en  (en[ST_AXY+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(tangential_p1_reg)),
        .b   (ay_reg),
        .p   (p1ay)
    );

    pdbc_qmul u_mul_r6
    (
        .clk (clk),
        .en  (en[ST_R4+1 +: MUL_LAT]),
        .a   (r4),
        .b   (r2_reg[ST_R4]),
        .p   (r6)
    );

    pdbc_qmul u_mul_k2r4
    (
        .clk (clk),
        .en  (en[ST_R4+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(radial_k2_reg)),
        .b   (r4),
        .p   (k2r4)
    );

    pdbc_qmul u_mul_k3r6
    (
        .clk (clk),
        .en  (en[ST_R6+1 +: MUL_LAT]),
        .a   (pdbc_pkg::mid_t'(radial_k3_reg)),
        .b   (r6),
        .p   (k3r6)
    );

    pdbc_qmul u_mul_xf
    (
        .clk (clk),
        .en  (en[ST_F+1 +: MUL_LAT]),
        .a   (x_reg[ST_F]),
        .b   (f_reg),
        .p   (xf)
    );

    pdbc_qmul u_mul_yf
    (
        .clk (clk),
        .en  (en[ST_F+1 +: MUL_LAT]),
        .a   (y_reg[ST_F]),
        .b   (f_reg),
        .p   (yf)
    );

    // ------------------------------------------------------------------------
    // Depth scaling and output registers.
    // ------------------------------------------------------------------------
    pdbc_scale u_scale_x
    (
        .clk   (clk),
        .en    (en[ST_U+1 +: pdbc_pkg::SCALE_LAT]),
        .u     (ux_reg),
        .depth (depth_reg[ST_U]),
        .point (point_x)
    );

    pdbc_scale u_scale_y
    (
        .clk   (clk),
        .en    (en[ST_U+1 +: pdbc_pkg::SCALE_LAT]),
        .u     (uy_reg),
        .depth (depth_reg[ST_U]),
        .point (point_y)
    );

    assign point_z = depth_reg[NUM_STAGES];

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_no_stall_when_output_moves : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall
    ) else $error("Input stalled although the output stage can move.");

    a_stall_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        ((&v_reg) && out_stall) |-> in_stall
    ) else $error("Input accepted while every stage is full and stalled.");

    a_output_has_source : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(v_reg[NUM_STAGES-1] || v_reg[NUM_STAGES])
    ) else $error("Output valid without a transaction in the last stages.");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the pixel deprojection block
// Drives pixels through the valid/stall input channel. It predicts each 3D
// point with its own fixed-point model of the Brown-Conrady correction and
// checks the output channel field by field. The run covers several camera
// register settings, from the reset defaults to saturating extremes, with
// random idle gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PIX_W     = pdbc_pkg::PIX_W;
    localparam int DEPTH_W   = pdbc_pkg::DEPTH_W;
    localparam int FOCAL_W   = pdbc_pkg::FOCAL_W;
    localparam int COEF_W    = pdbc_pkg::COEF_W;
    localparam int CFG_W     = pdbc_pkg::CFG_W;
    localparam int CFG_IDX_W = pdbc_pkg::CFG_IDX_W;
    localparam int MID_W     = pdbc_pkg::MID_W;
    localparam int OUT_W     = pdbc_pkg::OUT_W;
    localparam int Q_SHIFT   = pdbc_pkg::Q_SHIFT;
    localparam int OUT_SHIFT = pdbc_pkg::OUT_SHIFT;

    typedef struct packed {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        pdbc_pkg::depth_t  depth;
    } pixel_t;

    typedef struct packed {
        pdbc_pkg::out_t    x;
        pdbc_pkg::out_t    y;
        pdbc_pkg::depth_t  z;
    } point_t;

    localparam longint MID_LIM = (64'sd1 <<< (MID_W - 1)) - 1;
    localparam longint OUT_HI  = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint Q_UNIT  = 64'sd1 <<< Q_SHIFT;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;
    logic [DEPTH_W-1:0]   depth_mm;
    logic                 out_valid;
    logic                 out_stall;
    pdbc_pkg::out_t       point_x;
    pdbc_pkg::out_t       point_y;
    logic [DEPTH_W-1:0]   point_z;

    logic [31:0]              cam_principal;
    logic [FOCAL_W-1:0]       cam_inv_fx;
    logic [FOCAL_W-1:0]       cam_inv_fy;
    logic signed [COEF_W-1:0] cam_k1;
    logic signed [COEF_W-1:0] cam_k2;
    logic signed [COEF_W-1:0] cam_k3;
    logic signed [COEF_W-1:0] cam_p1;
    logic signed [COEF_W-1:0] cam_p2;

    pixel_t pending_pixels[$];
    point_t expected_points[$];
    pixel_t next_pixel;
    point_t due_point;
    point_t seen_point;

    int  issued_count;
    int  accepted_count;
    int  points_checked;
    int  error_count;
    int  settings_run;
    int  sender_idle_pct;
    int  recv_stall_pct;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    bit  hold_request;
    bit  in_taken;

    pixel_deprojection_brown_conrady dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .depth_mm  (depth_mm),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

    always #2 clk = ~clk;

    function automatic longint clamp_mid(input longint v);
        longint r;
        if (v > MID_LIM)
        begin
            r = MID_LIM;
        end
        else if (v < -MID_LIM)
        begin
            r = -MID_LIM;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Exact product, truncated toward zero by the Q.28 shift, then clamped.
    function automatic longint fixed_mul(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] shifted;
        longint       r;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ma} * {64'd0, mb};
        shifted = prod >> Q_SHIFT;
        if (shifted > 128'(MID_LIM))
        begin
            r = MID_LIM;
        end
        else
        begin
            r = longint'(shifted[63:0]);
        end
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic pdbc_pkg::out_t scale_to_mm(input pdbc_pkg::depth_t depth,
                                                   input longint u);
        logic [63:0]    mu;
        logic [63:0]    m;
        pdbc_pkg::out_t r;
        mu = (u < 0) ? 64'(-u) : 64'(u);
        m = (mu * {48'd0, depth}) >> OUT_SHIFT;
        if (u < 0)
        begin
            r = (m > 64'(OUT_HI)) ? pdbc_pkg::OUT_MIN : pdbc_pkg::out_t'(-longint'(m));
        end
        else
        begin
            r = (m > 64'(OUT_HI)) ? pdbc_pkg::OUT_MAX : pdbc_pkg::out_t'(m);
        end
        return r;
    endfunction

    function automatic point_t deproject(input pixel_t p);
        longint x;
        longint y;
        longint xx;
        longint yy;
        longint xy;
        longint r2;
        longint r4;
        longint r6;
        longint f;
        longint ax;
        longint ay;
        longint ux;
        longint uy;
        point_t pt;
        x = (longint'(p.col) - longint'(cam_principal[31:16])) * longint'(cam_inv_fx);
        y = (longint'(p.row) - longint'(cam_principal[15:0])) * longint'(cam_inv_fy);
        xx = fixed_mul(x, x);
        yy = fixed_mul(y, y);
        xy = fixed_mul(x, y);
        r2 = clamp_mid(xx + yy);
        r4 = fixed_mul(r2, r2);
        r6 = fixed_mul(r4, r2);
        f = clamp_mid(Q_UNIT + fixed_mul(longint'(cam_k1), r2)
                      + fixed_mul(longint'(cam_k2), r4)
                      + fixed_mul(longint'(cam_k3), r6));
        ax = clamp_mid(r2 + 2 * xx);
        ay = clamp_mid(r2 + 2 * yy);
        ux = clamp_mid(fixed_mul(x, f) + 2 * fixed_mul(longint'(cam_p1), xy)
                       + fixed_mul(longint'(cam_p2), ax));
        uy = clamp_mid(fixed_mul(y, f) + 2 * fixed_mul(longint'(cam_p2), xy)
                       + fixed_mul(longint'(cam_p1), ay));
        pt.x = scale_to_mm(p.depth, ux);
        pt.y = scale_to_mm(p.depth, uy);
        pt.z = p.depth;
        return pt;
    endfunction

    function automatic pixel_t random_pixel(input bit in_frame);
        pixel_t p;
        if (in_frame && $urandom_range(9) < 8)
        begin
            p.col = PIX_W'($urandom_range(10239));
            p.row = PIX_W'($urandom_range(7679));
        end
        else
        begin
            p.col = PIX_W'($urandom);
            p.row = PIX_W'($urandom);
        end
        case ($urandom_range(9))
            0:       p.depth = '0;
            1:       p.depth = '1;
            2, 3:    p.depth = DEPTH_W'($urandom);
            default: p.depth = DEPTH_W'($urandom_range(10000, 200));
        endcase
        return p;
    endfunction

    task automatic queue_pixel(input pixel_t p);
        pending_pixels.push_back(p);
        issued_count++;
    endtask

    // Corners of the 16-bit pixel coordinate range, zero and full depth, the principal point itself
    // and its neighbourhood, and alternating bit patterns.
    task automatic queue_directed();
        logic [PIX_W-1:0] cx;
        logic [PIX_W-1:0] cy;
        cx = cam_principal[31:16];
        cy = cam_principal[15:0];
        queue_pixel(pixel_t'{cx, cy, 16'd1000});
        queue_pixel(pixel_t'{16'h0000, 16'h0000, 16'h0000});
        queue_pixel(pixel_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_pixel(pixel_t'{16'h0000, 16'hFFFF, 16'hFFFF});
        queue_pixel(pixel_t'{16'hFFFF, 16'h0000, 16'h0001});
        queue_pixel(pixel_t'{cx - 16'd1, cy + 16'd1, 16'hFFFF});
        queue_pixel(pixel_t'{16'hAAAA, 16'h5555, 16'h5555});
        queue_pixel(pixel_t'{16'h5555, 16'hAAAA, 16'hAAAA});
    endtask

    task automatic write_reg(input pdbc_pkg::cfg_reg_e idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            pdbc_pkg::CFG_PRINCIPAL_POINT: cam_principal = value;
            pdbc_pkg::CFG_INV_FOCAL_X:     cam_inv_fx    = value[FOCAL_W-1:0];
            pdbc_pkg::CFG_INV_FOCAL_Y:     cam_inv_fy    = value[FOCAL_W-1:0];
            pdbc_pkg::CFG_RADIAL_K1:       cam_k1        = value;
            pdbc_pkg::CFG_RADIAL_K2:       cam_k2        = value;
            pdbc_pkg::CFG_RADIAL_K3:       cam_k3        = value;
            pdbc_pkg::CFG_TANGENTIAL_P1:   cam_p1        = value;
            pdbc_pkg::CFG_TANGENTIAL_P2:   cam_p2        = value;
            default:                       ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_camera(input logic [31:0] principal, input logic [31:0] fx,
                                input logic [31:0] fy, input logic [31:0] k1,
                                input logic [31:0] k2, input logic [31:0] k3,
                                input logic [31:0] p1, input logic [31:0] p2);
        write_reg(pdbc_pkg::CFG_PRINCIPAL_POINT, principal);
        write_reg(pdbc_pkg::CFG_INV_FOCAL_X, fx);
        write_reg(pdbc_pkg::CFG_INV_FOCAL_Y, fy);
        write_reg(pdbc_pkg::CFG_RADIAL_K1, k1);
        write_reg(pdbc_pkg::CFG_RADIAL_K2, k2);
        write_reg(pdbc_pkg::CFG_RADIAL_K3, k3);
        write_reg(pdbc_pkg::CFG_TANGENTIAL_P1, p1);
        write_reg(pdbc_pkg::CFG_TANGENTIAL_P2, p2);
        settings_run++;
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expected_points.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
                begin
                    send_gap = $urandom_range(19, 1) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_pixel = pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    pixel_x  <= next_pixel.col;
                    pixel_y  <= next_pixel.row;
                    depth_mm <= next_pixel.depth;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_left = 200;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
            begin
                stall_left = $urandom_range(19, 1) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                expected_points.push_back(deproject(pixel_t'{pixel_x, pixel_y, depth_mm}));
                accepted_count++;
            end
            if (out_valid && !out_stall)
            begin
                seen_point = '{point_x, point_y, point_z};
                if (expected_points.size() == 0)
                begin
                    $error("Point received with none outstanding: x %0d, y %0d, z %0d",
                           seen_point.x, seen_point.y, seen_point.z);
                    error_count++;
                end
                else
                begin
                    due_point = expected_points.pop_front();
                    if (seen_point.x !== due_point.x)
                    begin
                        $error("point_x: expected %0d, got %0d", due_point.x, seen_point.x);
                        error_count++;
                    end
                    if (seen_point.y !== due_point.y)
                    begin
                        $error("point_y: expected %0d, got %0d", due_point.y, seen_point.y);
                        error_count++;
                    end
                    if (seen_point.z !== due_point.z)
                    begin
                        $error("point_z: expected %0d, got %0d", due_point.z, seen_point.z);
                        error_count++;
                    end
                end
                points_checked++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $error("Timed out with %0d points outstanding", expected_points.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        depth_mm = '0;
        out_stall = 1'b0;
        cam_principal = '0;
        cam_inv_fx = pdbc_pkg::INV_FOCAL_RESET;
        cam_inv_fy = pdbc_pkg::INV_FOCAL_RESET;
        cam_k1 = '0;
        cam_k2 = '0;
        cam_k3 = '0;
        cam_p1 = '0;
        cam_p2 = '0;
        issued_count = 0;
        accepted_count = 0;
        points_checked = 0;
        error_count = 0;
        settings_run = 1;
        send_gap = 0;
        stall_left = 0;
        hold_left = 0;
        hold_request = 1'b0;
        in_taken = 1'b0;
        sender_idle_pct = 20;
        recv_stall_pct = 20;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        repeat (100) queue_pixel(random_pixel(1'b0));
        wait_drained();

        apply_camera({16'd5120, 16'd3840}, 32'd27962, 32'd27962, 32'sd26843546,
                     -32'sd53687091, 32'sd13421773, 32'sd268435, -32'sd134218);
        queue_directed();
        sender_idle_pct = 5;
        recv_stall_pct = 25;
        @(posedge clk);
        hold_request = 1'b1;
        repeat (350) queue_pixel(random_pixel(1'b1));
        wait_drained();

        apply_camera(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_directed();
        sender_idle_pct = 40;
        recv_stall_pct = 40;
        repeat (200) queue_pixel(random_pixel(1'b0));
        wait_drained();

        apply_camera(32'h0000_0000, 32'h0000_0000, 32'h00FF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        sender_idle_pct = 10;
        recv_stall_pct = 50;
        repeat (200) queue_pixel(random_pixel(1'b0));
        wait_drained();

        sender_idle_pct = 30;
        recv_stall_pct = 10;
        repeat (3)
        begin
            apply_camera($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            repeat (200) queue_pixel(random_pixel(1'($urandom_range(1))));
            wait_drained();
        end

        apply_camera({16'd5120, 16'd3840}, 32'd26000 + $urandom_range(4000),
                     32'd26000 + $urandom_range(4000),
                     int'($urandom_range(67108863)) - 33554432,
                     int'($urandom_range(67108863)) - 33554432,
                     int'($urandom_range(67108863)) - 33554432,
                     int'($urandom_range(1048575)) - 524288,
                     int'($urandom_range(1048575)) - 524288);
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (300) queue_pixel(random_pixel(1'b1));
        wait_drained();

        repeat (60) @(negedge clk);
        $display("Deprojected %0d pixels under %0d register settings, reset defaults to extremes.",
                 accepted_count, settings_run);
        $display("Checked %0d points with random gaps on both sides and one long output hold.",
                 points_checked);
        if (error_count == 0 && expected_points.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
